@@ rtl/msl_pkg.sv @@
// Shared types and constants for the masked seam Laplacian ratio block.
// No dependencies; the files that use it refer to it by scoped names.
package msl_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 25;
	localparam int GEO_W      = 16;
	localparam int SUM_W      = 48;
	localparam int CNT_W      = 25;
	localparam int PHASE_W    = 24;
	localparam int RATIO_W    = 32;
	localparam int PROD_W     = SUM_W + CNT_W;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STRIDE       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_EDGE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MASK_PRESENT = 3'd4;

	localparam logic [12:0]      RST_IMAGE_WIDTH  = 13'd1024;
	localparam logic [12:0]      RST_IMAGE_HEIGHT = 13'd1024;
	localparam logic [CNT_W-1:0] RST_STRIDE       = 25'd1;
	localparam logic [CNT_W-1:0] RST_MIN_EDGE     = 25'd16;
	localparam logic [CNT_W-1:0] STRIDE_MAX       = 25'h1000000;

	// One stencil evaluation, handed from the stencil unit to the accumulators.
	typedef struct packed {
		logic             valid;
		logic             edge_hit;
		logic             edge_ok;
		logic [SUM_W-1:0] edge_abs;
		logic             int_ok;
		logic [SUM_W-1:0] int_abs;
		logic             frame_end;
	} msl_evt_t;

	// Frame totals handed to the ratio unit.
	typedef struct packed {
		logic [SUM_W-1:0] edge_sum;
		logic [CNT_W-1:0] edge_used;
		logic [SUM_W-1:0] int_sum;
		logic [CNT_W-1:0] int_used;
		logic [CNT_W-1:0] edge_px;
		logic             meas;
	} msl_frame_t;

	typedef struct packed {
		logic [RATIO_W-1:0] ratio;
		logic               meas;
		logic [CNT_W-1:0]   edge_px;
		logic [CNT_W-1:0]   edge_used;
		logic [CNT_W-1:0]   int_used;
	} msl_result_t;

	// Previous row slot in a three-row store.
	function automatic logic [1:0] dec3(input logic [1:0] q);
		logic [1:0] r;
		case (q)
			2'd0:    r = 2'd2;
			2'd1:    r = 2'd0;
			2'd2:    r = 2'd1;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/msl_pix_if.sv @@
// Pixel input channel: valid/ready handshake with one pixel as payload.
// Depends on nothing.
interface msl_pix_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] pixel_value;
	logic                          pixel_finite;
	logic                          on_support;

	modport source(output valid, pixel_value, pixel_finite, on_support, input ready);
	modport sink(input valid, pixel_value, pixel_finite, on_support, output ready);
endinterface

@@ rtl/msl_res_if.sv @@
// Result output channel: valid/ready handshake with one frame score as payload.
// Depends on nothing.
interface msl_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] seam_ratio;
	logic        measurable;
	logic [24:0] edge_pixels;
	logic [24:0] edge_used;
	logic [24:0] interior_used;

	modport source(output valid, seam_ratio, measurable, edge_pixels, edge_used,
		interior_used, input ready);
	modport sink(input valid, seam_ratio, measurable, edge_pixels, edge_used,
		interior_used, output ready);
endinterface

@@ rtl/msl_stencil.sv @@
// Column-packed mask and pixel line stores, raster position tracking and
// the edge / interior stencil tests. Depends on msl_pkg.
module msl_stencil #(
	parameter int MAX_WIDTH   = 4096,
	parameter int MAX_HEIGHT  = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [SAMPLE_BITS-1:0]              in_value,
	input  logic                                in_finite,
	input  logic                                in_support,
	input  logic [msl_pkg::GEO_W-1:0]           geo_w,
	input  logic [msl_pkg::GEO_W-1:0]           geo_h,
	input  logic [msl_pkg::CNT_W-1:0]           stride,
	input  logic                                hold,
	output msl_pkg::msl_evt_t                   evt
);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int PW = SAMPLE_BITS + 1;
	localparam int AW = SAMPLE_BITS + 4;
	localparam int GW = msl_pkg::GEO_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_CALC = 2'd3;

	logic [1:0]                      state_q;
	logic [2:0]                      k_q, cap_k_q;
	logic                            cap_en_q;
	logic [CW-1:0]                   x_q;
	logic [RW-1:0]                   y_q;
	logic [1:0]                      y3_q;
	logic [msl_pkg::PHASE_W-1:0]     phase_q;
	logic [PW-1:0]                   cp_q;
	logic                            cm_q;
	logic [3:0]                      mcol_q [5];
	logic [3*PW-1:0]                 pcol_q [3];
	logic [3:0]                      mrd_q;
	logic [3*PW-1:0]                 prd_q;
	logic [3:0]                      mask_mem [MAX_WIDTH];
	logic [3*PW-1:0]                 pix_mem [MAX_WIDTH];
	msl_pkg::msl_evt_t               evt_q;

	logic [CW-1:0]  maddr, paddr;
	logic           wr_en, go;
	logic [3:0]     mwr;
	logic [3*PW-1:0] pwr;
	logic [1:0]     r1, r2, r3, r4, q1, q2, q3;
	logic [GW-1:0]  xg, yg;
	logic           edge_en, int_en, st, outer, int_mask, row_end, frame_end;
	logic           edge_fin, int_fin;
	logic [AW-1:0]  edge_lap, int_lap;
	logic [PW-1:0]  ec, el, er, eu, ed, ic, il, ir, iu;
	logic [msl_pkg::CNT_W-1:0] phase_inc;

	function automatic logic [AW-1:0] lap_abs(input logic [PW-1:0] c, l, r, u, d);
		logic signed [AW-1:0] v;
		v = ($signed({{4{c[SAMPLE_BITS-1]}}, c[SAMPLE_BITS-1:0]}) <<< 2)
			- $signed({{4{l[SAMPLE_BITS-1]}}, l[SAMPLE_BITS-1:0]})
			- $signed({{4{r[SAMPLE_BITS-1]}}, r[SAMPLE_BITS-1:0]})
			- $signed({{4{u[SAMPLE_BITS-1]}}, u[SAMPLE_BITS-1:0]})
			- $signed({{4{d[SAMPLE_BITS-1]}}, d[SAMPLE_BITS-1:0]});
		return v[AW-1] ? AW'(-v) : AW'(v);
	endfunction

	assign in_ready = (state_q == ST_IDLE);
	assign evt      = evt_q;

	assign maddr = x_q + CW'(k_q) - CW'(2);
	assign paddr = x_q + CW'(k_q) - CW'(1);

	// Row slots: mask store keeps four rows, pixel store three.
	assign r4 = y_q[1:0];
	assign r1 = r4 - 2'd1;
	assign r2 = r4 - 2'd2;
	assign r3 = r4 - 2'd3;
	assign q3 = y3_q;
	assign q1 = msl_pkg::dec3(y3_q);
	assign q2 = msl_pkg::dec3(q1);

	assign xg = GW'(x_q);
	assign yg = GW'(y_q);

	assign edge_en = yg >= GW'(4) && yg + GW'(1) <= geo_h && xg >= GW'(2) && xg + GW'(3) <= geo_w;
	assign int_en  = yg >= GW'(2) && yg + GW'(1) <= geo_h && xg >= GW'(1) && xg + GW'(2) <= geo_w
		&& phase_q == '0;

	assign st = mcol_q[2][r2] & mcol_q[1][r2] & mcol_q[3][r2] & mcol_q[2][r3] & mcol_q[2][r1];
	assign outer = mcol_q[0][r2] & mcol_q[4][r2] & mcol_q[2][r4] & cm_q
		& mcol_q[1][r3] & mcol_q[3][r3] & mcol_q[1][r1] & mcol_q[3][r1];
	assign int_mask = mcol_q[2][r1] & mcol_q[1][r1] & mcol_q[3][r1] & mcol_q[2][r2] & cm_q;

	assign ec = pcol_q[1][q2*PW +: PW];
	assign el = pcol_q[0][q2*PW +: PW];
	assign er = pcol_q[2][q2*PW +: PW];
	assign eu = pcol_q[1][q3*PW +: PW];
	assign ed = pcol_q[1][q1*PW +: PW];
	assign ic = pcol_q[1][q1*PW +: PW];
	assign il = pcol_q[0][q1*PW +: PW];
	assign ir = pcol_q[2][q1*PW +: PW];
	assign iu = pcol_q[1][q2*PW +: PW];

	assign edge_fin = ec[PW-1] & el[PW-1] & er[PW-1] & eu[PW-1] & ed[PW-1];
	assign int_fin  = ic[PW-1] & il[PW-1] & ir[PW-1] & iu[PW-1] & cp_q[PW-1];
	assign edge_lap = lap_abs(ec, el, er, eu, ed);
	assign int_lap  = lap_abs(ic, il, ir, iu, cp_q);

	assign row_end   = xg + GW'(1) >= geo_w;
	assign frame_end = row_end && yg + GW'(1) >= geo_h;
	assign go        = (state_q == ST_CALC) && !(frame_end && hold);
	assign wr_en     = go;
	assign phase_inc = {1'b0, phase_q} + msl_pkg::CNT_W'(1);

	// Write back column x with the new pixel in its row slot.
	always_comb begin
		mwr = mcol_q[2];
		mwr[r4] = cm_q;
		pwr = pcol_q[1];
		pwr[q3*PW +: PW] = cp_q;
	end

	always_ff @(posedge clk) begin
		mrd_q <= mask_mem[maddr];
		prd_q <= pix_mem[paddr];
		if (wr_en) begin
			mask_mem[x_q] <= mwr;
			pix_mem[x_q]  <= pwr;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cp_q <= {in_finite, in_value};
			cm_q <= in_support;
		end
		if (cap_en_q) begin
			mcol_q[cap_k_q] <= mrd_q;
			if (cap_k_q < 3'd3) begin
				pcol_q[cap_k_q[1:0]] <= prd_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			k_q      <= '0;
			cap_k_q  <= '0;
			cap_en_q <= 1'b0;
			x_q      <= '0;
			y_q      <= '0;
			y3_q     <= '0;
			phase_q  <= '0;
			evt_q    <= '0;
		end else begin
			cap_en_q    <= (state_q == ST_READ);
			cap_k_q     <= k_q;
			evt_q.valid <= go;
			case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (in_valid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd4) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (go) begin
						state_q            <= ST_IDLE;
						evt_q.edge_hit     <= edge_en & st & ~outer;
						evt_q.edge_ok      <= edge_en & st & ~outer & edge_fin;
						evt_q.edge_abs     <= msl_pkg::SUM_W'(edge_lap);
						evt_q.int_ok       <= int_en & int_mask & int_fin;
						evt_q.int_abs      <= msl_pkg::SUM_W'(int_lap);
						evt_q.frame_end    <= frame_end;
						if (frame_end) begin
							phase_q <= '0;
						end else if (y_q != '0) begin
							phase_q <= (phase_inc >= stride) ? '0 : phase_inc[msl_pkg::PHASE_W-1:0];
						end
						if (row_end) begin
							x_q <= '0;
							if (frame_end) begin
								y_q     <= '0;
								y3_q    <= '0;
							end else begin
								y_q  <= y_q + RW'(1);
								y3_q <= (y3_q == 2'd2) ? 2'd0 : y3_q + 2'd1;
							end
						end else begin
							x_q <= x_q + CW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/msl_ratio.sv @@
// End-of-frame ratio unit: shift-add products, then restoring division
// one quotient bit per cycle. Depends on msl_pkg.
module msl_ratio (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  msl_pkg::msl_frame_t   frame,
	input  logic                  take,
	output logic                  busy,
	output logic                  done,
	output msl_pkg::msl_result_t  result
);
	localparam int PW = msl_pkg::PROD_W;

	localparam logic [2:0] R_IDLE = 3'd0;
	localparam logic [2:0] R_MUL  = 3'd1;
	localparam logic [2:0] R_CHK  = 3'd2;
	localparam logic [2:0] R_DIV  = 3'd3;
	localparam logic [2:0] R_DONE = 3'd4;

	logic [2:0]                  state_q;
	logic [4:0]                  cnt_q;
	logic [PW-1:0]               a1_q, a2_q, acc1_q, acc2_q, rem_q;
	logic [msl_pkg::CNT_W-1:0]   b1_q, b2_q;
	logic                        es_zero_q;
	logic [31:0]                 low_q;
	msl_pkg::msl_result_t        res_q;
	logic [PW:0]                 rem_sh;
	logic                        fits;

	assign busy   = (state_q != R_IDLE);
	assign done   = (state_q == R_DONE);
	assign result = res_q;
	assign rem_sh = {rem_q, low_q[31]};
	assign fits   = rem_sh >= {1'b0, acc2_q};

	always_ff @(posedge clk) begin
		case (state_q)
			R_IDLE: begin
				if (start) begin
					a1_q      <= PW'(frame.edge_sum);
					b1_q      <= frame.int_used;
					a2_q      <= PW'(frame.int_sum);
					b2_q      <= frame.edge_used;
					acc1_q    <= '0;
					acc2_q    <= '0;
					es_zero_q <= (frame.edge_sum == '0);
					res_q.ratio     <= '0;
					res_q.meas      <= frame.meas;
					res_q.edge_px   <= frame.edge_px;
					res_q.edge_used <= frame.edge_used;
					res_q.int_used  <= frame.int_used;
				end
			end
			R_MUL: begin
				if (b1_q[0]) acc1_q <= acc1_q + a1_q;
				if (b2_q[0]) acc2_q <= acc2_q + a2_q;
				a1_q <= a1_q << 1;
				a2_q <= a2_q << 1;
				b1_q <= b1_q >> 1;
				b2_q <= b2_q >> 1;
			end
			R_CHK: begin
				// Numerator is acc1 scaled by 2^16; quotient overflows 32 bits
				// when its upper part already reaches the denominator.
				rem_q <= PW'(acc1_q[PW-1:16]);
				low_q <= {acc1_q[15:0], 16'd0};
				if (es_zero_q) begin
					res_q.ratio <= '0;
				end else if (PW'(acc1_q[PW-1:16]) >= acc2_q) begin
					res_q.ratio <= '1;
				end
			end
			R_DIV: begin
				low_q <= low_q << 1;
				rem_q <= fits ? PW'(rem_sh - {1'b0, acc2_q}) : rem_sh[PW-1:0];
				res_q.ratio <= {res_q.ratio[30:0], fits};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				R_IDLE: begin
					cnt_q <= '0;
					if (start) begin
						state_q <= frame.meas ? R_MUL : R_DONE;
					end
				end
				R_MUL: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(msl_pkg::CNT_W - 1)) begin
						state_q <= R_CHK;
					end
				end
				R_CHK: begin
					cnt_q <= '0;
					if (es_zero_q || PW'(acc1_q[PW-1:16]) >= acc2_q) begin
						state_q <= R_DONE;
					end else begin
						state_q <= R_DIV;
					end
				end
				R_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= R_DONE;
					end
				end
				R_DONE: begin
					if (take) begin
						state_q <= R_IDLE;
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/masked_seam_laplacian_ratio.sv @@
// Top level of the masked seam Laplacian ratio block: configuration
// registers, frame accumulators and result register. Depends on msl_pkg,
// msl_pix_if, msl_res_if, msl_stencil and msl_ratio.
//
// Pixels arrive in raster order, one per transfer on pix. Each pixel passes
// through the transfer, five reads of the column-packed line stores (mask
// columns x-2 to x+2, pixel columns x-1 to x+3, one read port per store),
// a wait for read data and a compute step that evaluates both stencils and
// writes column x back; only then is the next pixel taken. The stores hold
// no reset contents and get no clearing pass; entries a frame has not yet
// written read as undefined, which a frame of fixed geometry never observes.
// After the last pixel of a frame the totals go to the ratio unit, which
// runs up to 25 shift-add steps, one overflow check and 32 divide steps
// while the next frame streams in. The last pixel of a frame is held in its
// compute step while the ratio unit is still working on, or still holding,
// the previous frame's result; a result leaves the ratio unit once the
// output register is free or is being emptied, so a stalled result port stops
// intake only at a frame's last pixel. Write configuration only while idle.
module masked_seam_laplacian_ratio #(
	parameter int MAX_WIDTH   = 4096,
	parameter int MAX_HEIGHT  = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	msl_pix_if.sink                           pix,
	msl_res_if.source                         res,
	input  logic                              cfg_we,
	input  logic [msl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [msl_pkg::CFG_DATA_W-1:0]    cfg_data
);
	localparam int GW = msl_pkg::GEO_W;
	localparam int SW = msl_pkg::SUM_W;
	localparam int NW = msl_pkg::CNT_W;

	logic [12:0]   width_q, height_q;
	logic [NW-1:0] stride_q, min_edge_q;
	logic          mask_present_q;

	logic [GW-1:0] geo_w, geo_h;
	logic [NW-1:0] stride_eff;

	logic [NW-1:0] edge_px_q, edge_used_q, int_used_q;
	logic [SW-1:0] edge_sum_q, int_sum_q;
	logic [NW-1:0] edge_px_n, edge_used_n, int_used_n;
	logic [SW-1:0] edge_sum_n, int_sum_n;

	msl_pkg::msl_evt_t    evt;
	msl_pkg::msl_frame_t  frame;
	msl_pkg::msl_result_t result;
	logic                 ratio_busy, ratio_done, ratio_take;
	logic                 out_valid_q;

	// Clamp geometry and stride into the ranges the datapath supports.
	always_comb begin
		geo_w = GW'(width_q);
		if (width_q == '0) geo_w = GW'(1);
		else if (GW'(width_q) > GW'(MAX_WIDTH)) geo_w = GW'(MAX_WIDTH);
		geo_h = GW'(height_q);
		if (height_q == '0) geo_h = GW'(1);
		else if (GW'(height_q) > GW'(MAX_HEIGHT)) geo_h = GW'(MAX_HEIGHT);
		stride_eff = stride_q;
		if (stride_q == '0) stride_eff = NW'(1);
		else if (stride_q > msl_pkg::STRIDE_MAX) stride_eff = msl_pkg::STRIDE_MAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q        <= msl_pkg::RST_IMAGE_WIDTH;
			height_q       <= msl_pkg::RST_IMAGE_HEIGHT;
			stride_q       <= msl_pkg::RST_STRIDE;
			min_edge_q     <= msl_pkg::RST_MIN_EDGE;
			mask_present_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				msl_pkg::CFG_IMAGE_WIDTH:  width_q        <= cfg_data[12:0];
				msl_pkg::CFG_IMAGE_HEIGHT: height_q       <= cfg_data[12:0];
				msl_pkg::CFG_STRIDE:       stride_q       <= cfg_data;
				msl_pkg::CFG_MIN_EDGE:     min_edge_q     <= cfg_data;
				msl_pkg::CFG_MASK_PRESENT: mask_present_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	msl_stencil #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_stencil (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix.valid),
		.in_ready  (pix.ready),
		.in_value  (pix.pixel_value),
		.in_finite (pix.pixel_finite),
		.in_support(pix.on_support),
		.geo_w     (geo_w),
		.geo_h     (geo_h),
		.stride    (stride_eff),
		.hold      (ratio_busy),
		.evt       (evt)
	);

	// Totals including the pixel just evaluated.
	assign edge_px_n   = edge_px_q + NW'(evt.edge_hit);
	assign edge_used_n = edge_used_q + NW'(evt.edge_ok);
	assign int_used_n  = int_used_q + NW'(evt.int_ok);
	assign edge_sum_n  = evt.edge_ok ? edge_sum_q + evt.edge_abs : edge_sum_q;
	assign int_sum_n   = evt.int_ok ? int_sum_q + evt.int_abs : int_sum_q;

	always_comb begin
		frame.edge_sum  = edge_sum_n;
		frame.edge_used = edge_used_n;
		frame.int_sum   = int_sum_n;
		frame.int_used  = int_used_n;
		frame.edge_px   = edge_px_n;
		frame.meas      = mask_present_q && edge_px_n >= min_edge_q
			&& edge_used_n != '0 && int_used_n != '0;
	end

	// Accumulate each evaluated pixel; clear at the end of a frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_px_q   <= '0;
			edge_used_q <= '0;
			int_used_q  <= '0;
			edge_sum_q  <= '0;
			int_sum_q   <= '0;
		end else if (evt.valid) begin
			if (evt.frame_end) begin
				edge_px_q   <= '0;
				edge_used_q <= '0;
				int_used_q  <= '0;
				edge_sum_q  <= '0;
				int_sum_q   <= '0;
			end else begin
				edge_px_q   <= edge_px_n;
				edge_used_q <= edge_used_n;
				int_used_q  <= int_used_n;
				edge_sum_q  <= edge_sum_n;
				int_sum_q   <= int_sum_n;
			end
		end
	end

	msl_ratio u_ratio (
		.clk   (clk),
		.arst_n(arst_n),
		.start (evt.valid && evt.frame_end),
		.frame (frame),
		.take  (ratio_take),
		.busy  (ratio_busy),
		.done  (ratio_done),
		.result(result)
	);

	// Move a finished score into the output register once it is free or being emptied.
	assign ratio_take = ratio_done && (!out_valid_q || res.ready);
	assign res.valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ratio_take) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ratio_take) begin
			res.seam_ratio    <= result.meas ? result.ratio : '0;
			res.measurable    <= result.meas;
			res.edge_pixels   <= result.edge_px;
			res.edge_used     <= result.edge_used;
			res.interior_used <= result.int_used;
		end
	end

endmodule

@@ tb/tb.sv @@
// Testbench for masked_seam_laplacian_ratio: streams raster frames, predicts each
// frame score in a local model and checks every result transfer field by field.
// Depends on msl_pkg, msl_pix_if, msl_res_if and the RTL of the block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [15:0] value;
		bit                 finite;
		bit                 support;
	} pixel_t;

	localparam int MODE_RECT   = 0;
	localparam int MODE_FULL   = 1;
	localparam int MODE_SPARSE = 2;
	localparam int MODE_FLAT   = 3;
	localparam int MODE_SMALL  = 4;

	localparam int SCORE_DEPTH = 16;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [msl_pkg::CFG_IDX_W-1:0]  cfg_index = msl_pkg::CFG_IMAGE_WIDTH;
	logic [msl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	msl_pix_if #(.SAMPLE_BITS(16)) pix();
	msl_res_if                     res();

	masked_seam_laplacian_ratio dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Score model: configuration copy, line stores and frame accumulators.
	logic [12:0]  width_reg = 13'd1024;
	logic [12:0]  height_reg = 13'd1024;
	logic [24:0]  stride_reg = 25'd1;
	logic [24:0]  min_edge_reg = 25'd16;
	bit           mask_reg = 1'b1;
	bit           mask_store [4][4096];
	logic [16:0]  sample_store [3][4096];
	int unsigned  col_pos, row_pos, phase;
	logic [24:0]  edge_count, edge_finite, interior_finite;
	logic [47:0]  edge_total, interior_total;

	// Predicted scores, oldest at score_rd.
	msl_pkg::msl_result_t score_mem [SCORE_DEPTH];
	int           score_wr = 0;
	int           score_rd = 0;
	int           errors = 0;
	int           send_idle = 0;
	int           stall_pct = 0;
	int           hold_left = 0;
	int           items_sent = 0;

	function automatic bit mask_at(int unsigned r, int unsigned c);
		return mask_store[r % 4][c];
	endfunction

	function automatic logic [16:0] sample_at(int unsigned r, int unsigned c);
		return sample_store[r % 3][c];
	endfunction

	// Absolute 5-point Laplacian, -1 when any stencil sample is non-finite.
	function automatic longint laplace_abs(logic [16:0] c, logic [16:0] l, logic [16:0] r,
			logic [16:0] u, logic [16:0] d);
		longint v;
		if (!(c[16] & l[16] & r[16] & u[16] & d[16]))
			return -1;
		v = 4 * longint'($signed(c[15:0])) - longint'($signed(l[15:0]))
			- longint'($signed(r[15:0])) - longint'($signed(u[15:0]))
			- longint'($signed(d[15:0]));
		return v < 0 ? -v : v;
	endfunction

	// Q16.16 quotient of the two means, floored and saturated.
	function automatic logic [31:0] mean_ratio(logic [47:0] es, logic [24:0] en,
			logic [47:0] is, logic [24:0] in);
		logic [127:0] num, den, q;
		if (is == 0)
			return es == 0 ? 32'd0 : 32'hFFFF_FFFF;
		num = (128'(es) * 128'(in)) << 16;
		den = 128'(en) * 128'(is);
		q = num / den;
		return (q >> 32) != 0 ? 32'hFFFF_FFFF : q[31:0];
	endfunction

	function automatic void clear_frame();
		col_pos = 0;
		row_pos = 0;
		phase = 0;
		edge_count = '0;
		edge_finite = '0;
		interior_finite = '0;
		edge_total = '0;
		interior_total = '0;
	endfunction

	// Advance the model by one accepted pixel; done is set on the frame's last pixel.
	function automatic void score_pixel(input pixel_t p, output bit done,
			output msl_pkg::msl_result_t r);
		int unsigned w, h, s, x, y, cy;
		bit          st, outer, cm;
		logic [16:0] cp;
		longint      v;
		w = width_reg < 1 ? 1 : (width_reg > 4096 ? 4096 : width_reg);
		h = height_reg < 1 ? 1 : (height_reg > 4096 ? 4096 : height_reg);
		s = stride_reg < 1 ? 1 : (stride_reg > 25'h1000000 ? 25'h1000000 : stride_reg);
		x = col_pos;
		y = row_pos;
		cm = p.support;
		cp = {p.finite, p.value};
		done = 1'b0;
		r = '0;
		// edge test, centered two rows up
		if (y >= 4 && y + 1 <= h && x >= 2 && x + 3 <= w) begin
			cy = y - 2;
			st = mask_at(cy, x) && mask_at(cy, x - 1) && mask_at(cy, x + 1)
				&& mask_at(cy - 1, x) && mask_at(cy + 1, x);
			outer = mask_at(cy, x - 2) && mask_at(cy, x + 2) && mask_at(cy - 2, x) && cm
				&& mask_at(cy - 1, x - 1) && mask_at(cy - 1, x + 1)
				&& mask_at(cy + 1, x - 1) && mask_at(cy + 1, x + 1);
			if (st && !outer) begin
				edge_count++;
				v = laplace_abs(sample_at(cy, x), sample_at(cy, x - 1), sample_at(cy, x + 1),
					sample_at(cy - 1, x), sample_at(cy + 1, x));
				if (v >= 0) begin
					edge_finite++;
					edge_total += 48'(v);
				end
			end
		end
		// strided interior test, centered one row up
		if (y >= 2 && y + 1 <= h && x >= 1 && x + 2 <= w && phase == 0) begin
			cy = y - 1;
			if (mask_at(cy, x) && mask_at(cy, x - 1) && mask_at(cy, x + 1)
					&& mask_at(cy - 1, x) && cm) begin
				v = laplace_abs(sample_at(cy, x), sample_at(cy, x - 1), sample_at(cy, x + 1),
					sample_at(cy - 1, x), cp);
				if (v >= 0) begin
					interior_finite++;
					interior_total += 48'(v);
				end
			end
		end
		mask_store[y % 4][x] = cm;
		sample_store[y % 3][x] = cp;
		if (y >= 1)
			phase = (phase + 1 >= s) ? 0 : phase + 1;
		if (x + 1 >= w) begin
			col_pos = 0;
			if (y + 1 >= h) begin
				r.meas = mask_reg && edge_count >= min_edge_reg && edge_finite != 0
					&& interior_finite != 0;
				r.ratio = r.meas ? mean_ratio(edge_total, edge_finite, interior_total,
					interior_finite) : 32'd0;
				r.edge_px = edge_count;
				r.edge_used = edge_finite;
				r.int_used = interior_finite;
				done = 1'b1;
				clear_frame();
			end else begin
				row_pos = y + 1;
			end
		end else begin
			col_pos = x + 1;
		end
	endfunction

	function automatic void note_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			errors++;
			if (errors <= 10)
				$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
		end
	endfunction

	// Check every result transfer against the oldest predicted score.
	always @(posedge clk) begin
		msl_pkg::msl_result_t e;
		if (arst_n && res.valid && res.ready) begin
			if (score_wr == score_rd) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected result, ratio %0h", $time, res.seam_ratio);
			end else begin
				e = score_mem[score_rd % SCORE_DEPTH];
				score_rd++;
				note_field("seam_ratio", e.ratio, res.seam_ratio);
				note_field("measurable", e.meas, res.measurable);
				note_field("edge_pixels", e.edge_px, res.edge_pixels);
				note_field("edge_used", e.edge_used, res.edge_used);
				note_field("interior_used", e.int_used, res.interior_used);
			end
		end
	end

	// Result sink: random stalls, plus a long hold-off when requested.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			res.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			res.ready <= $urandom_range(99) >= stall_pct;
		end
	end

	task automatic write_reg(logic [msl_pkg::CFG_IDX_W-1:0] idx,
			logic [msl_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			msl_pkg::CFG_IMAGE_WIDTH:  width_reg = val[12:0];
			msl_pkg::CFG_IMAGE_HEIGHT: height_reg = val[12:0];
			msl_pkg::CFG_STRIDE:       stride_reg = val;
			msl_pkg::CFG_MIN_EDGE:     min_edge_reg = val;
			msl_pkg::CFG_MASK_PRESENT: mask_reg = val[0];
			default:          ;
		endcase
		@(posedge clk);
	endtask

	task automatic configure(int w, int h, logic [24:0] stride, logic [24:0] min_edge,
			bit present);
		write_reg(msl_pkg::CFG_IMAGE_WIDTH, 25'(w));
		write_reg(msl_pkg::CFG_IMAGE_HEIGHT, 25'(h));
		write_reg(msl_pkg::CFG_STRIDE, stride);
		write_reg(msl_pkg::CFG_MIN_EDGE, min_edge);
		write_reg(msl_pkg::CFG_MASK_PRESENT, 25'(present));
		cfg_we <= 1'b0;
	endtask

	// Offer one pixel, idling first at random, and hold it until the transfer.
	task automatic send_pixel(pixel_t p, bit typed, msl_pkg::msl_result_t typed_score);
		bit                   done;
		msl_pkg::msl_result_t r;
		while ($urandom_range(99) < send_idle) begin
			pix.valid <= 1'b0;
			@(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.pixel_value <= p.value;
		pix.pixel_finite <= p.finite;
		pix.on_support <= p.support;
		do
			@(posedge clk);
		while (!pix.ready);
		items_sent++;
		score_pixel(p, done, r);
		if (done) begin
			score_mem[score_wr % SCORE_DEPTH] = typed ? typed_score : r;
			score_wr++;
		end
	endtask

	// Drop valid, wait for every score, then let the ratio unit settle.
	task automatic drain();
		pix.valid <= 1'b0;
		while (score_wr != score_rd)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// Frame content: support region and flat level shared by the pixels of a frame.
	int rx0, rx1, ry0, ry1;
	logic signed [15:0] flat_level;

	function automatic pixel_t make_pixel(int mode, int x, int y);
		pixel_t p;
		bit     in_rect, rim;
		in_rect = x >= rx0 && x <= rx1 && y >= ry0 && y <= ry1;
		rim = in_rect && (x <= rx0 + 1 || x >= rx1 - 1 || y <= ry0 + 1 || y >= ry1 - 1);
		p.value = 16'($urandom);
		p.finite = $urandom_range(29) != 0;
		p.support = in_rect;
		case (mode)
			MODE_FULL: p.support = 1'b1;
			MODE_SPARSE: p.support = $urandom_range(3) != 0;
			MODE_FLAT: begin
				// flat interior with rough rim: small or zero interior mean
				p.finite = 1'b1;
				if (!(rim && $urandom_range(2) == 0))
					p.value = flat_level;
			end
			MODE_SMALL: begin
				p.finite = $urandom_range(49) != 0;
				p.value = 16'($signed($urandom_range(16)) - 8);
			end
			default: ;
		endcase
		return p;
	endfunction

	task automatic send_frame(int w, int h);
		int mode;
		mode = $urandom_range(MODE_SMALL);
		rx0 = $urandom_range(w / 2);
		rx1 = $urandom_range(w - 1, rx0);
		ry0 = $urandom_range(h / 2);
		ry1 = $urandom_range(h - 1, ry0);
		flat_level = 16'($urandom);
		for (int y = 0; y < h; y++)
			for (int x = 0; x < w; x++)
				send_pixel(make_pixel(mode, x, y), 1'b0, '0);
	endtask

	// Directed 5x5 frame: field extremes, a non-finite corner, an off-support corner.
	// {support, finite, value}
	localparam logic [17:0] DIRECTED [25] = '{
		{2'b10, 16'h7FFF}, {2'b11, 16'h8000}, {2'b11, 16'h0000}, {2'b11, 16'hFFFF},
		{2'b11, 16'h0001},
		{2'b11, 16'h8000}, {2'b11, 16'h7FFF}, {2'b11, 16'h8000}, {2'b11, 16'h7FFF},
		{2'b11, 16'h5555},
		{2'b11, 16'hAAAA}, {2'b11, 16'h8000}, {2'b11, 16'h7FFF}, {2'b11, 16'h8000},
		{2'b11, 16'h0000},
		{2'b11, 16'h1234}, {2'b11, 16'h7FFF}, {2'b11, 16'h8000}, {2'b11, 16'h7FFF},
		{2'b11, 16'hFFFF},
		{2'b11, 16'h0001}, {2'b11, 16'hFFFF}, {2'b11, 16'h0000}, {2'b11, 16'h7FFF},
		{2'b01, 16'h8000}
	};

	initial begin
		pix.valid = 1'b0;
		pix.pixel_value = '0;
		pix.pixel_finite = 1'b0;
		pix.on_support = 1'b0;
		res.ready = 1'b0;
		clear_frame();
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4096; c++)
				mask_store[r][c] = 1'b0;
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 4096; c++)
				sample_store[r][c] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frame: support off at one corner, no mask declared, nine interior stencils.
		configure(5, 5, 25'd1, 25'd0, 1'b0);
		begin
			msl_pkg::msl_result_t known;
			pixel_t               p;
			known = '0;
			known.int_used = 25'd9;
			for (int i = 0; i < 25; i++) begin
				p.support = DIRECTED[i][17];
				p.finite = DIRECTED[i][16];
				p.value = DIRECTED[i][15:0];
				send_pixel(p, 1'b1, known);
			end
		end
		drain();

		// Pressure: hold the sink while several frames of one geometry stream in.
		configure(6, 5, 25'd1, 25'd1, 1'b1);
		hold_left = 4000;
		repeat (4) send_frame(6, 5);
		drain();

		// Extreme register values on small frames: stride and edge floor at
		// their maximum, stride zero, then zero geometry that clamps to one pixel.
		configure(5, 5, 25'h1000000, 25'h1000000, 1'b1);
		send_frame(5, 5);
		drain();
		configure(7, 6, 25'd0, 25'd0, 1'b1);
		send_frame(7, 6);
		drain();
		configure(0, 0, 25'd1, 25'd0, 1'b1);
		repeat (3) send_frame(1, 1);
		drain();

		// Random groups of frames; idling style rotates with the group number.
		for (int g = 0; items_sent < 1950; g++) begin
			int          w, h;
			logic [24:0] stride, min_edge;
			case (g % 4)
				0: begin send_idle = 0;  stall_pct = 0;  end
				1: begin send_idle = 70; stall_pct = 0;  end
				2: begin send_idle = 0;  stall_pct = 70; end
				default: begin send_idle = 22; stall_pct = 22; end
			endcase
			w = $urandom_range(12, 5);
			h = $urandom_range(9, 5);
			case ($urandom_range(3))
				0: stride = 25'd1;
				1: stride = 25'($urandom_range(7, 2));
				2: stride = 25'($urandom_range(40, 8));
				default: stride = $urandom_range(7) == 0 ? 25'h1000000 : 25'd3;
			endcase
			case ($urandom_range(3))
				0: min_edge = 25'd0;
				1: min_edge = 25'($urandom_range(8, 1));
				2: min_edge = 25'd16;
				default: min_edge = $urandom_range(3) == 0 ? 25'h1000000 : 25'd2;
			endcase
			configure(w, h, stride, min_edge, $urandom_range(7) != 0);
			repeat ($urandom_range(3, 1)) send_frame(w, h);
			drain();
		end

		send_idle = 0;
		stall_pct = 0;
		repeat (200) @(posedge clk);
		if (errors == 0 && score_wr == score_rd) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
